// File: design/civil_date_day_number_converter_assert.svh
// Assertion macros used by the checker of the civil date converter.
`ifndef CIVIL_DATE_DAY_NUMBER_CONVERTER_ASSERT_SVH
`define CIVIL_DATE_DAY_NUMBER_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CDDNC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CDDNC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/cddnc_pkg.sv
// Types, constants and calendar tables of the civil date converter.
package cddnc_pkg;

	// Field widths.
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned SERIAL_W = 22;
	localparam int unsigned WDAY_W   = 3;

	// Default last valid year.
	localparam int unsigned MAX_YEAR_DEF = 9999;

	// Configuration port.
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic [0:0] REG_WEEKDAY_OFFSET = 1'b0;
	localparam logic [WDAY_W-1:0] WEEKDAY_OFFSET_RESET = 3'd1;

	// Calendar constants.
	localparam int unsigned DAYS_PER_YEAR   = 365;
	localparam int unsigned MONTHS_PER_YEAR = 12;
	localparam int unsigned DAYS_PER_WEEK   = 7;
	localparam logic [MONTH_W-1:0] LAST_MONTH_IDX = 4'd11;
	localparam logic [MONTH_W-1:0] MARCH_IDX      = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
	localparam logic [MONTH_W-1:0] SEARCH_TOP     = 4'b1000;

	// Working widths: day counts reach the last day of the widest year field.
	localparam int unsigned ACC_W = 23;
	localparam int unsigned REM_W = 22;
	localparam int unsigned CUM_W = 9;

	// Greedy decomposition steps: power-of-two multiples of 400-year, 100-year, 4-year and 1-year groups.
	localparam int unsigned NUM_STEPS      = 15;
	localparam int unsigned STEP_W         = 4;
	localparam int unsigned FIRST_LOW_STEP = 6;
	localparam int unsigned QBITS_W        = 9;
	localparam logic [4:0]  Q4_CENTURY     = 5'd24;
	localparam logic [1:0]  Q_TOP          = 2'd3;

	typedef logic [ACC_W-1:0]  days_t;
	typedef logic [YEAR_W-1:0] years_t;

	localparam days_t STEP_DAYS [NUM_STEPS] = '{
		23'd4675104, 23'd2337552, 23'd1168776, 23'd584388, 23'd292194, 23'd146097,
		23'd73048, 23'd36524,
		23'd23376, 23'd11688, 23'd5844, 23'd2922, 23'd1461,
		23'd730, 23'd365
	};

	localparam years_t STEP_YEARS [NUM_STEPS] = '{
		14'd12800, 14'd6400, 14'd3200, 14'd1600, 14'd800, 14'd400,
		14'd200, 14'd100,
		14'd64, 14'd32, 14'd16, 14'd8, 14'd4,
		14'd2, 14'd1
	};

	localparam logic [CUM_W-1:0] MONTH_CUM [MONTHS_PER_YEAR] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS_PER_YEAR] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic {
		REQ_TO_SERIAL   = 1'b0,
		REQ_FROM_SERIAL = 1'b1
	} req_type_t;

	// A year is leap when it closes a 4-year group that is not the last one of a
	// century, or closes the fourth century of a 400-year cycle.
	function automatic logic leap_of(input logic [QBITS_W-1:0] qbits);
		logic [1:0] q100;
		logic [4:0] q4;
		logic [1:0] q1;
		q100 = qbits[8:7];
		q4   = qbits[6:2];
		q1   = qbits[1:0];
		return (q1 == Q_TOP) && ((q4 != Q4_CENTURY) || (q100 == Q_TOP));
	endfunction

	// Days before month index idx (0 = January); zero past December.
	function automatic logic [CUM_W-1:0] month_cum(input logic [MONTH_W-1:0] idx,
			input logic leap);
		logic [CUM_W-1:0] base;
		base = '0;
		if (idx <= LAST_MONTH_IDX) begin
			base = MONTH_CUM[idx];
			if (leap && (idx >= MARCH_IDX)) begin
				base = base + CUM_W'(1);
			end
		end
		return base;
	endfunction

	// Length of month 1..12; zero for any other code.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
			input logic leap);
		logic [MONTH_W-1:0] idx;
		logic [DAY_W-1:0] len;
		idx = month - MONTH_W'(1);
		len = '0;
		if ((month != '0) && (idx <= LAST_MONTH_IDX)) begin
			len = MONTH_LEN[idx];
			if (leap && (month == MONTH_FEB)) begin
				len = len + DAY_W'(1);
			end
		end
		return len;
	endfunction

	// Remainder by seven through octal digit sums, since eight is one modulo seven.
	function automatic logic [WDAY_W-1:0] mod7(input logic [ACC_W:0] v);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [2:0] s3;
		s1 = '0;
		for (int i = 0; i < (ACC_W + 1) / 3; i++) begin
			s1 = s1 + 6'(v[3*i +: 3]);
		end
		s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
		s3 = s2[2:0] + 3'(s2[3]);
		return (s3 == 3'(DAYS_PER_WEEK)) ? 3'd0 : s3;
	endfunction

endpackage

// File: design/cddnc_if.sv
// Request and result channel interfaces of the civil date converter.
interface cddnc_req_if import cddnc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [YEAR_W-1:0]   in_year;
	logic [MONTH_W-1:0]  in_month;
	logic [DAY_W-1:0]    in_day;
	logic [SERIAL_W-1:0] in_serial;

	modport source (output valid, req_type, in_year, in_month, in_day, in_serial,
		input ready);
	modport sink (input valid, req_type, in_year, in_month, in_day, in_serial,
		output ready);
endinterface

interface cddnc_rsp_if import cddnc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [YEAR_W-1:0]   out_year;
	logic [MONTH_W-1:0]  out_month;
	logic [DAY_W-1:0]    out_day;
	logic [SERIAL_W-1:0] out_serial;
	logic [WDAY_W-1:0]   out_weekday;
	logic                bad_input;

	modport source (output valid, out_year, out_month, out_day, out_serial, out_weekday,
		bad_input, input ready);
	modport sink (input valid, out_year, out_month, out_day, out_serial, out_weekday,
		bad_input, output ready);
endinterface

// File: design/civil_date_day_number_converter.sv
// Flow: a date request runs the 15 greedy steps of the shared subtract and add unit
// and then the total; a day number request runs the 15 greedy steps, the 4-step month
// search and the day step; a rejected request goes straight to the result. No new
// request is taken until the previous result has been loaded into the result register.
// Reset: arst_n clears the sequencer and the result valid and sets weekday_offset to 1.
module civil_date_day_number_converter import cddnc_pkg::*; #(
	parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cddnc_req_if.sink             req,
	cddnc_rsp_if.source           rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	// Day number of the last day of MAX_YEAR.
	localparam int unsigned MAX_SERIAL = DAYS_PER_YEAR * MAX_YEAR + MAX_YEAR / 4
		- MAX_YEAR / 100 + MAX_YEAR / 400 - 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_SEARCH,
		ST_DAY,
		ST_TOTAL,
		ST_FINISH
	} state_t;

	state_t               state_q;
	req_type_t            mode_q;
	logic [STEP_W-1:0]    step_q;
	logic [REM_W-1:0]     rem_q;
	logic [ACC_W-1:0]     acc_q;
	logic [QBITS_W-1:0]   qbits_q;
	logic [MONTH_W-1:0]   mon_q;
	logic [1:0]           bit_q;
	logic [YEAR_W-1:0]    year_q;
	logic [MONTH_W-1:0]   month_q;
	logic [DAY_W-1:0]     day_q;
	logic [SERIAL_W-1:0]  serial_q;
	logic                 bad_q;
	logic [WDAY_W-1:0]    offset_q;

	logic                 out_valid_q;
	logic [YEAR_W-1:0]    out_year_q;
	logic [MONTH_W-1:0]   out_month_q;
	logic [DAY_W-1:0]     out_day_q;
	logic [SERIAL_W-1:0]  out_serial_q;
	logic [WDAY_W-1:0]    out_weekday_q;
	logic                 out_bad_q;

	logic                 leap;
	logic [MONTH_W-1:0]   cand;
	logic [ACC_W-1:0]     sub_b;
	logic [ACC_W-1:0]     add_b;
	logic [ACC_W:0]       diff;
	logic                 ge;
	logic [ACC_W-1:0]     sum;
	logic [ACC_W-1:0]     full_serial;
	logic [WDAY_W-1:0]    weekday;
	logic                 year_ok;
	logic                 month_ok;
	logic                 serial_ok;
	logic                 rsp_load;

	// Configuration register; writes complete in the access phase.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WEEKDAY_OFFSET) ? CFG_DATA_W'(offset_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= WEEKDAY_OFFSET_RESET;
		end else if (psel && penable && pwrite && pready &&
				(paddr[2] == REG_WEEKDAY_OFFSET)) begin
			offset_q <= pwdata[WDAY_W-1:0];
		end
	end

	// Leap flag of the current year, taken from its decomposition.
	assign leap = leap_of(qbits_q);
	assign cand = mon_q | (SEARCH_TOP >> bit_q);

	// Operand selection for the shared subtract and compare unit and the accumulator.
	always_comb begin
		sub_b = '0;
		add_b = '0;
		case (state_q)
			ST_STEP: begin
				if (mode_q == REQ_FROM_SERIAL) begin
					sub_b = STEP_DAYS[step_q];
					add_b = ACC_W'(STEP_YEARS[step_q]);
				end else begin
					sub_b = ACC_W'(STEP_YEARS[step_q]);
					add_b = STEP_DAYS[step_q];
				end
			end
			ST_SEARCH: sub_b = ACC_W'(month_cum(cand, leap));
			ST_DAY:    sub_b = ACC_W'(month_cum(mon_q, leap));
			ST_TOTAL: begin
				add_b = ACC_W'(month_cum(month_q - MONTH_W'(1), leap))
					+ ACC_W'(day_q) - ACC_W'(1);
			end
			default: begin
				sub_b = '0;
				add_b = '0;
			end
		endcase
	end

	assign diff = {1'b0, ACC_W'(rem_q)} - {1'b0, sub_b};
	assign ge   = !diff[ACC_W];
	assign sum  = acc_q + add_b;

	// Weekday of the finished day number.
	assign full_serial = (mode_q == REQ_FROM_SERIAL) ? ACC_W'(serial_q) : acc_q;
	assign weekday = mod7({1'b0, full_serial} + (ACC_W + 1)'(offset_q));

	// Checks made when a request is accepted.
	assign year_ok   = (req.in_year != '0) && (32'(req.in_year) <= MAX_YEAR);
	assign month_ok  = (req.in_month != '0) &&
		(req.in_month <= MONTH_W'(MONTHS_PER_YEAR));
	assign serial_ok = 32'(req.in_serial) <= MAX_SERIAL;

	assign req.ready = (state_q == ST_IDLE);

	// The result register takes a new result once the previous one has been taken.
	assign rsp_load = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && !rsp_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						mode_q   <= req_type_t'(req.req_type);
						step_q   <= '0;
						acc_q    <= '0;
						qbits_q  <= '0;
						year_q   <= req.in_year;
						month_q  <= req.in_month;
						day_q    <= req.in_day;
						serial_q <= req.in_serial;
						bad_q    <= 1'b0;
						if (req.req_type == REQ_FROM_SERIAL) begin
							rem_q <= req.in_serial;
							if (serial_ok) begin
								state_q <= ST_STEP;
							end else begin
								bad_q   <= 1'b1;
								state_q <= ST_FINISH;
							end
						end else begin
							rem_q <= REM_W'(req.in_year - YEAR_W'(1));
							if (year_ok && month_ok && (req.in_day != '0)) begin
								state_q <= ST_STEP;
							end else begin
								bad_q   <= 1'b1;
								state_q <= ST_FINISH;
							end
						end
					end
				end
				ST_STEP: begin
					// Take the group when it fits and count it in the accumulator.
					if (ge) begin
						rem_q <= diff[REM_W-1:0];
						acc_q <= sum;
					end
					if (32'(step_q) >= FIRST_LOW_STEP) begin
						qbits_q <= {qbits_q[QBITS_W-2:0], ge};
					end
					if (32'(step_q) == NUM_STEPS - 1) begin
						mon_q <= '0;
						bit_q <= '0;
						state_q <= (mode_q == REQ_FROM_SERIAL) ? ST_SEARCH : ST_TOTAL;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_SEARCH: begin
					// Binary search for the last month that starts on or before the day.
					if ((cand <= LAST_MONTH_IDX) && ge) begin
						mon_q <= cand;
					end
					if (bit_q == 2'd3) begin
						state_q <= ST_DAY;
					end else begin
						bit_q <= bit_q + 2'd1;
					end
				end
				ST_DAY: begin
					rem_q   <= diff[REM_W-1:0];
					state_q <= ST_FINISH;
				end
				ST_TOTAL: begin
					acc_q <= sum;
					if (day_q > month_len(month_q, leap)) begin
						bad_q <= 1'b1;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (rsp_load) begin
						out_valid_q <= 1'b1;
						out_bad_q   <= bad_q;
						if (bad_q) begin
							out_year_q    <= '0;
							out_month_q   <= '0;
							out_day_q     <= '0;
							out_serial_q  <= '0;
							out_weekday_q <= '0;
						end else if (mode_q == REQ_FROM_SERIAL) begin
							out_year_q    <= acc_q[YEAR_W-1:0] + YEAR_W'(1);
							out_month_q   <= mon_q + MONTH_W'(1);
							out_day_q     <= rem_q[DAY_W-1:0] + DAY_W'(1);
							out_serial_q  <= serial_q;
							out_weekday_q <= weekday;
						end else begin
							out_year_q    <= year_q;
							out_month_q   <= month_q;
							out_day_q     <= day_q;
							out_serial_q  <= acc_q[SERIAL_W-1:0];
							out_weekday_q <= weekday;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.out_year    = out_year_q;
	assign rsp.out_month   = out_month_q;
	assign rsp.out_day     = out_day_q;
	assign rsp.out_serial  = out_serial_q;
	assign rsp.out_weekday = out_weekday_q;
	assign rsp.bad_input   = out_bad_q;

endmodule

// File: design/cddnc_checker.sv
// Port-level assertions of the civil date converter and their bind.
`include "civil_date_day_number_converter_assert.svh"

module cddnc_checker import cddnc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [YEAR_W-1:0]   out_year,
	input logic [MONTH_W-1:0]  out_month,
	input logic [DAY_W-1:0]    out_day,
	input logic [SERIAL_W-1:0] out_serial,
	input logic [WDAY_W-1:0]   out_weekday,
	input logic                bad_input
);

	logic rsp_stall;
	logic req_taken;
	logic rsp_good;
	logic rsp_bad;
	logic zero_fields;
	logic sane_fields;
	logic [YEAR_W+MONTH_W+DAY_W+SERIAL_W+WDAY_W:0] rsp_word;

	assign rsp_stall = rsp_valid && !rsp_ready;
	assign req_taken = req_valid && req_ready;
	assign rsp_good  = rsp_valid && !bad_input;
	assign rsp_bad   = rsp_valid && bad_input;
	assign rsp_word  = {out_year, out_month, out_day, out_serial, out_weekday, bad_input};
	assign zero_fields = (out_year == '0) && (out_month == '0) && (out_day == '0) &&
		(out_serial == '0) && (out_weekday == '0);
	assign sane_fields = (out_month != '0) && (out_month <= MONTH_W'(MONTHS_PER_YEAR)) &&
		(out_day != '0) && (out_weekday != WDAY_W'(DAYS_PER_WEEK));

	// A stalled result stays offered and unchanged.
	`CDDNC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "result changed")
	// The converter works on one request at a time.
	`CDDNC_ASSERT_NEXT(a_busy_after_take, req_taken, !req_ready, "ready while busy")
	// A rejected request carries no date, day number or weekday.
	`CDDNC_ASSERT_NOW(a_bad_zero, rsp_bad, zero_fields, "rejected result not cleared")
	// An accepted request gives a real month, day and weekday.
	`CDDNC_ASSERT_NOW(a_good_sane, rsp_good, sane_fields, "result fields out of range")

endmodule

bind civil_date_day_number_converter cddnc_checker u_cddnc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.out_year    (rsp.out_year),
	.out_month   (rsp.out_month),
	.out_day     (rsp.out_day),
	.out_serial  (rsp.out_serial),
	.out_weekday (rsp.out_weekday),
	.bad_input   (rsp.bad_input)
);
